// ===== design/pfp_pkg.sv =====
`default_nettype none
package pfp_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int DATA_WORDS  = 13;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int IDX_W       = 4;

    localparam logic [7:0]  HEAD_FIRST   = 8'h42;
    localparam logic [7:0]  HEAD_SECOND  = 8'h4D;
    localparam logic [15:0] LEN_EXPECTED = 16'd28;

    localparam logic [ADDR_W-1:0] OFS_FIRST  = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] OFS_SECOND = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] OFS_LEN_LO = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] OFS_CSUM   = ADDR_W'(FRAME_BYTES - 2);
    localparam logic [ADDR_W-1:0] OFS_END    = ADDR_W'(FRAME_BYTES - 1);
    localparam logic [ADDR_W-1:0] OFS_DATA   = ADDR_W'(4);

    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(DATA_WORDS - 1);

    localparam logic ST_DATA  = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage
`default_nettype wire

// ===== design/particle_sensor_frame_parser_unit.sv =====
// Receive: one byte per cycle while o_s_tready is high; each accepted byte is
// written to the frame RAM. Checksum mismatch: the error result is valid in the
// cycle after the last byte. Match: data words are read from the frame RAM one
// byte per cycle (hi, lo) via RDHI, RDLO, LOAD; a word is read only once the
// output register is empty; no byte is taken during readout. Sync reset clears
// state, offset and output valid; frame RAM contents stay undefined, no clear pass.
`default_nettype none
module particle_sensor_frame_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [3:0] word_index, [19:4] word_value, pad
    output logic             o_m_tuser,   // [0] status
    output logic             o_m_tlast    // last
);
    import pfp_pkg::*;

    localparam logic [1:0] S_RX   = 2'd0;
    localparam logic [1:0] S_RDHI = 2'd1;
    localparam logic [1:0] S_RDLO = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_ofs, n_ofs;
    logic [15:0]       r_sum, n_sum;
    logic [7:0]        r_prev;
    logic [7:0]        r_hi;
    logic [IDX_W-1:0]  r_widx, n_widx;
    logic              r_out_valid, n_out_valid;
    logic              r_out_st, n_out_st;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [15:0]       r_out_val, n_out_val;
    logic              r_out_last, n_out_last;

    t_ram_req          ram_req;
    logic [7:0]        ram_rdata;
    logic              in_acc;
    logic              out_acc;
    logic [ADDR_W-1:0] hi_addr;

    pfp_frame_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_RX) && !((r_ofs == OFS_END) && r_out_valid);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = r_out_valid && i_m_tready;
    assign hi_addr    = ADDR_W'({r_widx, 1'b0}) + OFS_DATA;

    always_comb begin
        ram_req.we    = in_acc;
        ram_req.waddr = r_ofs;
        ram_req.wdata = i_s_tdata;
        ram_req.re    = 1'b0;
        ram_req.raddr = hi_addr;
        if (r_state == S_RDHI) begin
            ram_req.re = !r_out_valid;
        end else if (r_state == S_RDLO) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = hi_addr | ADDR_W'(1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ofs       = r_ofs;
        n_sum       = r_sum;
        n_widx      = r_widx;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        n_out_st    = r_out_st;
        n_out_idx   = r_out_idx;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_RX: begin
                if (in_acc) begin
                    n_ofs = r_ofs + ADDR_W'(1);
                    if (r_ofs == OFS_FIRST) begin
                        n_sum = 16'(i_s_tdata);
                    end else if (r_ofs < OFS_CSUM) begin
                        n_sum = r_sum + 16'(i_s_tdata);
                    end
                    if (r_ofs == OFS_FIRST && i_s_tdata != HEAD_FIRST) begin
                        n_ofs = OFS_FIRST;
                    end
                    if (r_ofs == OFS_SECOND && i_s_tdata != HEAD_SECOND) begin
                        n_ofs = OFS_FIRST;
                    end
                    if (r_ofs == OFS_LEN_LO && {r_prev, i_s_tdata} != LEN_EXPECTED) begin
                        n_ofs = OFS_FIRST;
                    end
                    if (r_ofs == OFS_END) begin
                        n_ofs = OFS_FIRST;
                        if ({r_prev, i_s_tdata} == r_sum) begin
                            n_widx  = '0;
                            n_state = S_RDHI;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_st    = ST_ERROR;
                            n_out_idx   = '0;
                            n_out_val   = r_sum;
                            n_out_last  = 1'b1;
                        end
                    end
                end
            end
            S_RDHI: begin
                if (!r_out_valid) begin
                    n_state = S_RDLO;
                end
            end
            S_RDLO: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_out_st    = ST_DATA;
                n_out_idx   = r_widx;
                n_out_val   = {r_hi, ram_rdata};
                n_out_last  = (r_widx == IDX_LAST);
                if (r_widx == IDX_LAST) begin
                    n_state = S_RX;
                end else begin
                    n_widx  = r_widx + IDX_W'(1);
                    n_state = S_RDHI;
                end
            end
            default: n_state = S_RX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RX;
            r_ofs       <= OFS_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ofs       <= n_ofs;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum      <= n_sum;
        r_widx     <= n_widx;
        r_out_st   <= n_out_st;
        r_out_idx  <= n_out_idx;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
        if (in_acc) begin
            r_prev <= i_s_tdata;
        end
        if (r_state == S_RDLO) begin
            r_hi <= ram_rdata;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_val, r_out_idx};
    assign o_m_tuser  = r_out_st;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_no_rx_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RX) |-> !o_s_tready)
        else $error("byte accepted during readout");
    a_load_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_out_valid)
        else $error("output register overwritten");
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st == ST_ERROR) |-> (r_out_last && r_out_idx == '0))
        else $error("error result not last");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RX) |-> (r_widx <= IDX_LAST))
        else $error("word index out of range");
    a_match_starts_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_ofs == OFS_END && {r_prev, i_s_tdata} == r_sum)
        |=> (r_state == S_RDHI && r_ofs == OFS_FIRST))
        else $error("readout not started on checksum match");
`endif

endmodule
`default_nettype wire

// ===== design/pfp_frame_ram.sv =====
`default_nettype none
module pfp_frame_ram (
    input  wire logic              i_clk,
    input  wire pfp_pkg::t_ram_req i_req,
    output logic [7:0]             o_rdata
);
    import pfp_pkg::*;

    logic [7:0] r_mem [FRAME_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule
`default_nettype wire
